// File: rtl/bcc_pkg.sv
// package with shared types and constants for the button click classifier
package bcc_pkg;

  // tick counter width and the width used for compares against registers
  localparam int COUNT_WIDTH = 16;
  localparam int DEB_W       = 10;
  localparam int LONG_W      = 16;
  localparam int GAP_W       = 14;
  localparam int CMP_W       = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd20;
  localparam logic [LONG_W-1:0] LONG_RST     = 16'd2000;
  localparam logic [GAP_W-1:0]  GAP_RST      = 14'd300;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HELD1 = 2'd1,
    PH_WAIT  = 2'd2,
    PH_HELD2 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } event_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [LONG_W-1:0] long_ticks;
    logic [GAP_W-1:0]  gap_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] elapsed;
  } fsm_stat_t;

endpackage

// File: rtl/bcc_if.sv
// valid/ready channel interfaces for input ticks and click results
interface bcc_in_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink   (input valid, input pressed, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] click_event;

  modport source (output valid, output click_event, input ready);
  modport sink   (input valid, input click_event, output ready);
endinterface

// File: rtl/bcc_cfg_regs.sv
// configuration register file for the button click classifier
module bcc_cfg_regs import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ticks = cfg_wdata[DEB_W-1:0];
        CFG_LONG:     cfg_nxt.long_ticks     = cfg_wdata[LONG_W-1:0];
        CFG_GAP:      cfg_nxt.gap_ticks      = cfg_wdata[GAP_W-1:0];
        default:      cfg_nxt                = cfg_r;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.long_ticks     <= LONG_RST;
      cfg_r.gap_ticks      <= GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/bcc_fsm.sv
// click phase state machine with saturating tick counter
module bcc_fsm import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      pressed,
  input  cfg_t      cfg,
  output event_t    ev,
  output fsm_stat_t stat
);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                   clr;
  logic                   lt_deb, lt_long, ge_gap;

  // counter advances at the start of every tick, saturating at all ones
  assign cnt_inc = (&cnt_r) ? cnt_r : COUNT_WIDTH'(cnt_r + 1'b1);

  assign lt_deb  = CMP_W'(cnt_inc) <  CMP_W'(cfg.debounce_ticks);
  assign lt_long = CMP_W'(cnt_inc) <  CMP_W'(cfg.long_ticks);
  assign ge_gap  = CMP_W'(cnt_inc) >= CMP_W'(cfg.gap_ticks);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (pressed) phase_nxt = PH_HELD1;
      end
      PH_HELD1: begin
        if (!pressed) begin
          if (lt_deb)       phase_nxt = PH_IDLE;
          else if (lt_long) phase_nxt = PH_WAIT;
          else              phase_nxt = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (pressed)     phase_nxt = PH_HELD2;
        else if (ge_gap) phase_nxt = PH_IDLE;
      end
      PH_HELD2: begin
        if (!pressed) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // event and counter marker
  always_comb begin
    ev  = EV_NONE;
    clr = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        clr = pressed;
      end
      PH_HELD1: begin
        if (!pressed && !lt_deb) begin
          if (lt_long)     clr = 1'b1;
          else if (ge_gap) ev  = EV_SINGLE;
        end
      end
      PH_WAIT: begin
        if (pressed)     clr = 1'b1;
        else if (ge_gap) ev  = EV_SINGLE;
      end
      PH_HELD2: begin
        if (!pressed && lt_long) ev = EV_DOUBLE;
      end
      default: begin
        ev  = EV_NONE;
        clr = 1'b0;
      end
    endcase
  end

  assign cnt_nxt = clr ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign stat.phase   = phase_r;
  assign stat.elapsed = cnt_r;

endmodule

// File: rtl/button_click_classifier.sv
// top level of the button click classifier
// Each input item is one millisecond tick carrying the button level; every item
// yields exactly one result item with click_event 0 (none), 1 (single click) or
// 2 (double click). Throughput is one item per clock while results are taken:
// the tick is captured in an input register, then the phase machine and tick
// counter update as the event is written to the output register, which offers
// the result. The output register lets a new item enter while a finished result
// waits; the whole pipe only stalls when the output is full and not taken.
// Registers (debounce_ticks, long_ticks, gap_ticks) are written through
// cfg_we/cfg_index/cfg_wdata and should only change while no item is in flight;
// an index beyond the third register is ignored.
module button_click_classifier import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bcc_in_if.sink                in_ch,
  bcc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  event_t    ev;
  fsm_stat_t stat;

  // input stage
  logic   s1_valid_r, s1_valid_nxt;
  logic   s1_pressed_r;
  // result stage
  logic   out_valid_r, out_valid_nxt;
  event_t out_event_r;

  logic en;       // result register free this cycle
  logic in_take;  // item accepted
  logic step;     // item moves through the state machine

  assign en      = !out_valid_r || out_ch.ready;
  assign step    = s1_valid_r && en;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || en;

  assign s1_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = en ? s1_valid_r : out_valid_r;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pressed (s1_pressed_r),
    .cfg     (cfg),
    .ev      (ev),
    .stat    (stat)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pressed_r <= in_ch.pressed;
    end
    if (step) begin
      out_event_r <= ev;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.click_event = out_event_r;

  // a press seen while idle sets the marker and enters the first press phase
  a_press_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && stat.phase == PH_IDLE && s1_pressed_r)
      |=> (stat.phase == PH_HELD1 && stat.elapsed == '0))
    else $error("press from idle did not start first press");

  // a double click only comes from release of the second press
  a_double_src: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ev == EV_DOUBLE) |-> (stat.phase == PH_HELD2 && !s1_pressed_r))
    else $error("double click outside second press release");

  // the input side only stalls when both stages hold items
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipe");

  // state holds while no item steps through
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(stat))
    else $error("state changed without an item");

endmodule

// File: sim/tb_button_click_classifier.sv
// testbench for the button click classifier: tick stimulus, click prediction and result check
`timescale 1ns / 1ps

module tb_button_click_classifier;
  import bcc_pkg::*;

  // index past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bcc_in_if  in_ch ();
  bcc_out_if out_ch ();

  button_click_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // button levels waiting to be sent, one per tick item
  bit tick_queue[$];
  // click events predicted for accepted ticks, oldest first
  event_t expected_clicks[$];

  // idle odds in percent for the sender and the receiver
  int send_idle_pct;
  int recv_idle_pct;
  int ticks_queued;
  int results_seen;
  int mismatches;
  logic [1:0] click_want;

  // our own copy of the registers and of the classifier state
  logic [DEB_W-1:0]       deb_reg;
  logic [LONG_W-1:0]      long_reg;
  logic [GAP_W-1:0]       gap_reg;
  phase_t                 tick_phase;
  logic [COUNT_WIDTH-1:0] tick_count;

  // advance the classifier by one tick and return the click it reports
  function automatic event_t classify_tick(input logic down);
    event_t ev;
    ev = EV_NONE;
    // counter runs every tick and sticks at all ones
    if (tick_count != '1) tick_count = COUNT_WIDTH'(tick_count + 1'b1);
    case (tick_phase)
      PH_IDLE: begin
        if (down) begin
          tick_count = '0;
          tick_phase = PH_HELD1;
        end
      end
      PH_HELD1: begin
        if (!down) begin
          if (CMP_W'(tick_count) < CMP_W'(deb_reg)) begin
            // bounce, too short to count
            tick_phase = PH_IDLE;
          end else if (CMP_W'(tick_count) < CMP_W'(long_reg)) begin
            // short press, wait for a second one
            tick_count = '0;
            tick_phase = PH_WAIT;
          end else begin
            // long press, single only if the gap has also passed
            tick_phase = PH_IDLE;
            if (CMP_W'(tick_count) >= CMP_W'(gap_reg)) ev = EV_SINGLE;
          end
        end
      end
      PH_WAIT: begin
        if (down) begin
          tick_count = '0;
          tick_phase = PH_HELD2;
        end else if (CMP_W'(tick_count) >= CMP_W'(gap_reg)) begin
          tick_phase = PH_IDLE;
          ev = EV_SINGLE;
        end
      end
      default: begin
        // second press: double only if released in time
        if (!down) begin
          if (CMP_W'(tick_count) < CMP_W'(long_reg)) ev = EV_DOUBLE;
          tick_phase = PH_IDLE;
        end
      end
    endcase
    return ev;
  endfunction

  // sender: predicts on every accepted tick, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.pressed <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_clicks.push_back(classify_tick(in_ch.pressed));
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.pressed <= tick_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen = results_seen + 1;
        if (expected_clicks.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result %0d: click_event %0d arrived with nothing expected",
                     results_seen, out_ch.click_event);
        end else begin
          click_want = expected_clicks.pop_front();
          if (out_ch.click_event !== click_want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result %0d: click_event expected %0d got %0d",
                       results_seen, click_want, out_ch.click_event);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // wait until no tick is queued or offered and no click is outstanding
  task automatic wait_drained();
    @(negedge clk);
    while (tick_queue.size() != 0 || in_ch.valid || expected_clicks.size() != 0)
      @(negedge clk);
  endtask

  // one register write, mirrored into our copy with the width cut applied
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DEBOUNCE: deb_reg  = data[DEB_W-1:0];
      CFG_LONG:     long_reg = data[LONG_W-1:0];
      CFG_GAP:      gap_reg  = data[GAP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // write all three registers, with junk in the bits above each register
  task automatic set_config(input int d, input int l, input int g);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[DEB_W-1:0] = DEB_W'(d);
    write_reg(CFG_DEBOUNCE, data);
    write_reg(CFG_LONG, CFG_DATA_W'(l));
    data = CFG_DATA_W'($urandom);
    data[GAP_W-1:0] = GAP_W'(g);
    write_reg(CFG_GAP, data);
  endtask

  // switch idle odds on a falling edge so the clocked blocks see a clean change
  task automatic start_phase(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic add_levels(input bit lvl, input int n);
    repeat (n) tick_queue.push_back(lvl);
    ticks_queued = ticks_queued + n;
  endtask

  // a length near one of two thresholds, sometimes anything up to two past it, or a short one
  function automatic int pick_len(input int a, input int b);
    int t;
    int len;
    t = $urandom_range(1) ? a : b;
    case ($urandom_range(4))
      0: len = t - 1;
      1: len = t;
      2: len = t + 1;
      3: len = $urandom_range(t + 2, 1);
      default: len = $urandom_range(4, 1);
    endcase
    if (len < 1) len = 1;
    return len;
  endfunction

  // mostly press / release shapes with an optional second press, sometimes plain noise
  task automatic add_press_sequence();
    int deb;
    int lng;
    int gap;
    deb = int'(deb_reg);
    lng = int'(long_reg);
    gap = int'(gap_reg);
    if ($urandom_range(9) < 8) begin
      add_levels(1'b1, pick_len(deb, lng));
      add_levels(1'b0, pick_len(gap, gap));
      if ($urandom_range(1)) add_levels(1'b1, pick_len(lng, deb));
      // tail long enough for a pending single click most of the time
      add_levels(1'b0, pick_len(gap, gap) + 1);
    end else begin
      repeat ($urandom_range(8, 1)) add_levels(1'($urandom_range(1)), 1);
    end
  endtask

  // queue sequences for the current settings until the tick budget is spent
  task automatic run_random(input int budget);
    int target;
    target = ticks_queued + budget;
    while (ticks_queued < target) add_press_sequence();
    wait_drained();
  endtask

  task automatic run_small_random(input int budget);
    set_config($urandom_range(6, 0), $urandom_range(20, 0), $urandom_range(14, 0));
    start_phase(send_idle_pct, recv_idle_pct);
    run_random(budget);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DEBOUNCE;
    cfg_wdata     = '0;
    send_idle_pct = 11;
    recv_idle_pct = 52;
    ticks_queued  = 0;
    results_seen  = 0;
    mismatches    = 0;
    deb_reg       = DEBOUNCE_RST;
    long_reg      = LONG_RST;
    gap_reg       = GAP_RST;
    tick_phase    = PH_IDLE;
    tick_count    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, with a dropped write to the spare index: short press then single
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    start_phase(11, 52);
    add_levels(1'b1, 21);
    add_levels(1'b0, 301);
    wait_drained();

    // directed: bounce, single after the gap, double, long press single
    set_config(2, 4, 3);
    start_phase(11, 52);
    add_levels(1'b1, 1);
    add_levels(1'b0, 1);
    add_levels(1'b1, 2);
    add_levels(1'b0, 4);
    add_levels(1'b1, 2);
    add_levels(1'b0, 1);
    add_levels(1'b1, 2);
    add_levels(1'b0, 1);
    add_levels(1'b1, 5);
    add_levels(1'b0, 1);
    wait_drained();

    // all registers zero: every press is long and reports at once
    set_config(0, 0, 0);
    start_phase(11, 52);
    add_levels(1'b1, 1);
    add_levels(1'b0, 1);
    wait_drained();

    // debounce above long, then a long press that ends before the gap
    set_config(3, 1, 5);
    start_phase(11, 52);
    add_levels(1'b1, 2);
    add_levels(1'b0, 1);
    add_levels(1'b1, 3);
    add_levels(1'b0, 1);
    wait_drained();

    // zero gap: single on the first released tick of the wait
    set_config(1, 5, 0);
    start_phase(11, 52);
    add_levels(1'b1, 1);
    add_levels(1'b0, 2);
    wait_drained();

    // random, sender idles rarely and receiver often
    start_phase(11, 52);
    for (int i = 0; i < 3; i++) run_small_random(65);

    // random, the other way round
    start_phase(52, 11);
    for (int i = 0; i < 3; i++) run_small_random(65);
    set_config(0, 0, 0);
    start_phase(52, 11);
    run_random(60);

    // random with no idling at all
    start_phase(0, 0);
    for (int i = 0; i < 3; i++) run_small_random(65);

    // register maxima: a short press is a bounce
    set_config(1023, 65535, 16383);
    start_phase(0, 0);
    add_levels(1'b1, 3);
    add_levels(1'b0, 2);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_clicks.size() == 0) begin
      $display("tb_button_click_classifier passed");
    end else begin
      $display("tb_button_click_classifier failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("tb_button_click_classifier failed");
    $finish;
  end

endmodule
